@@ rtl/dft_pkg.sv @@
// ----------------------------------------------------------------------------
// dft_pkg
// Shared types and constants of the destination failure tracker.
// ----------------------------------------------------------------------------
package dft_pkg;

    localparam int NUM_DESTINATIONS_DEF = 64;
    localparam int REQUESTER_BITS_DEF   = 16;

    // fixed field widths
    localparam int OPCODE_W    = 2;
    localparam int DEST_W      = 6;
    localparam int REQ_IN_W    = 16;
    localparam int THR_W       = 8;
    localparam int FC_W        = 8;
    localparam int CC_W        = 16;
    localparam int TOTAL_OUT_W = 7;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd3;

    typedef enum logic [1:0] {
        OP_SOFT_FAIL = 2'd0,
        OP_HARD_FAIL = 2'd1,
        OP_SUCCESS   = 2'd2,
        OP_REMOVE    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_CLEAR = 3'd0,
        S_IDLE  = 3'd1,
        S_READ  = 3'd2,
        S_EXEC  = 3'd3,
        S_OUT   = 3'd4
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic rd;
        logic exec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
    } t_sts;

endpackage

@@ rtl/dft_table.sv @@
// ----------------------------------------------------------------------------
// dft_table
// Per-destination entry store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dft_table #(
    parameter int DEPTH   = 64,
    parameter int ADDR_W  = 6,
    parameter int ENTRY_W = 42
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [ADDR_W-1:0]  i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dft_datapath.sv @@
// ----------------------------------------------------------------------------
// dft_datapath
// Request registers, entry update logic, knockout totals and result register.
// ----------------------------------------------------------------------------
module dft_datapath #(
    parameter int NUM_DESTINATIONS = 64,
    parameter int REQUESTER_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dft_pkg::t_cmd                  i_cmd,
    output dft_pkg::t_sts                  o_sts,
    input  logic                           i_cfg_wr_en,
    input  logic [dft_pkg::THR_W-1:0]      i_cfg_wr_data,
    input  logic [dft_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [dft_pkg::DEST_W-1:0]     i_dest_index,
    input  logic [dft_pkg::REQ_IN_W-1:0]   i_requester_id,
    output logic [dft_pkg::OUT_TDATA_W-1:0] o_result
);
    import dft_pkg::*;

    localparam int ADDR_W  = (NUM_DESTINATIONS > 1) ? $clog2(NUM_DESTINATIONS) : 1;
    localparam int TOT_W   = $clog2(NUM_DESTINATIONS + 1);
    localparam int ENTRY_W = FC_W + 2 + REQUESTER_BITS + CC_W;
    localparam int KO_B    = FC_W;
    localparam int HD_B    = FC_W + 1;
    localparam int OWN_L   = FC_W + 2;
    localparam int CC_L    = FC_W + 2 + REQUESTER_BITS;

    logic [THR_W-1:0]          r_thr;
    t_opcode                   r_op;
    logic [ADDR_W-1:0]         r_addr;
    logic                      r_oor;
    logic [REQUESTER_BITS-1:0] r_req;
    logic [ADDR_W-1:0]         r_clr_addr;
    logic [TOT_W-1:0]          r_soft;
    logic [TOT_W-1:0]          r_hard;
    logic [OUT_TDATA_W-1:0]    r_out;

    logic [TOT_W-1:0]          n_soft;
    logic [TOT_W-1:0]          n_hard;
    logic [OUT_TDATA_W-1:0]    n_out;
    logic [ENTRY_W-1:0]        n_entry;

    logic [31:0]               dest_wide;
    logic [31:0]               req_wide;
    logic [ENTRY_W-1:0]        rdata;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [ENTRY_W-1:0]        mem_wdata;

    assign dest_wide = 32'(i_dest_index);
    assign req_wide  = 32'(i_requester_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_opcode'(i_opcode);
            r_addr <= dest_wide[ADDR_W-1:0];
            r_oor  <= (dest_wide >= 32'(NUM_DESTINATIONS));
            r_req  <= req_wide[REQUESTER_BITS-1:0];
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr && !o_sts.clr_last) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == ADDR_W'(NUM_DESTINATIONS - 1));

    assign mem_we    = i_cmd.clr_wr || (i_cmd.exec && !r_oor);
    assign mem_waddr = i_cmd.clr_wr ? r_clr_addr : r_addr;
    assign mem_wdata = i_cmd.clr_wr ? '0 : n_entry;

    dft_table #(
        .DEPTH   (NUM_DESTINATIONS),
        .ADDR_W  (ADDR_W),
        .ENTRY_W (ENTRY_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        logic [FC_W-1:0]           fc;
        logic                      ko;
        logic                      hd;
        logic [REQUESTER_BITS-1:0] own;
        logic [CC_W-1:0]           cc;
        logic [CC_W-1:0]           cc_inc;
        logic [THR_W-1:0]          thr_eff;
        logic                      owns;
        logic                      resp;
        logic                      soft_inc;
        logic                      soft_dec;
        logic                      hard_inc;
        logic                      hard_dec;
        logic [31:0]               soft_w;
        logic [31:0]               hard_w;

        fc  = rdata[FC_W-1:0];
        ko  = rdata[KO_B];
        hd  = rdata[HD_B];
        own = rdata[OWN_L +: REQUESTER_BITS];
        cc  = rdata[CC_L +: CC_W];

        cc_inc   = (cc == '1) ? cc : cc + 1'b1;
        thr_eff  = (r_thr == '0) ? THR_W'(1) : r_thr;
        owns     = ko && (own == r_req);
        resp     = 1'b0;
        soft_inc = 1'b0;
        soft_dec = 1'b0;
        hard_inc = 1'b0;
        hard_dec = 1'b0;

        case (r_op)
            OP_SOFT_FAIL: begin
                cc = cc_inc;
                if (!ko) begin
                    if (({1'b0, fc} + 9'd1) >= {1'b0, thr_eff}) begin
                        ko       = 1'b1;
                        hd       = 1'b0;
                        own      = r_req;
                        fc       = '0;
                        soft_inc = 1'b1;
                        resp     = 1'b1;
                    end else begin
                        fc = fc + 1'b1;
                    end
                end
            end
            OP_HARD_FAIL: begin
                cc = cc_inc;
                if (ko && hd) begin
                    // already hard, nothing else changes
                end else if (owns) begin
                    hd       = 1'b1;
                    soft_dec = 1'b1;
                    hard_inc = 1'b1;
                end else if (!ko) begin
                    ko       = 1'b1;
                    hd       = 1'b1;
                    own      = r_req;
                    fc       = '0;
                    hard_inc = 1'b1;
                    resp     = 1'b1;
                end
            end
            OP_SUCCESS, OP_REMOVE: begin
                if (owns) begin
                    hard_dec = hd;
                    soft_dec = !hd;
                    fc       = '0;
                    ko       = 1'b0;
                    hd       = 1'b0;
                    own      = '0;
                    cc       = '0;
                    resp     = 1'b1;
                end else if (r_op == OP_SUCCESS && !ko && fc != '0) begin
                    fc = '0;
                    cc = '0;
                end
            end
            default: begin
            end
        endcase

        n_entry = {cc, own, hd, ko, fc};

        n_soft = r_soft;
        n_hard = r_hard;
        if (!r_oor) begin
            if (soft_inc) begin
                n_soft = r_soft + 1'b1;
            end else if (soft_dec && r_soft != '0) begin
                n_soft = r_soft - 1'b1;
            end
            if (hard_inc) begin
                n_hard = r_hard + 1'b1;
            end else if (hard_dec && r_hard != '0) begin
                n_hard = r_hard - 1'b1;
            end
        end

        soft_w = 32'(n_soft);
        hard_w = 32'(n_hard);

        if (r_oor) begin
            n_out = {6'b0, hard_w[TOTAL_OUT_W-1:0], soft_w[TOTAL_OUT_W-1:0],
                     CC_W'(0), 4'b0};
        end else begin
            n_out = {6'b0, hard_w[TOTAL_OUT_W-1:0], soft_w[TOTAL_OUT_W-1:0],
                     cc, (ko && !hd), (ko && hd), ko, resp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft <= '0;
            r_hard <= '0;
        end else if (i_cmd.exec) begin
            r_soft <= n_soft;
            r_hard <= n_hard;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

@@ rtl/dft_ctrl.sv @@
// ----------------------------------------------------------------------------
// dft_ctrl
// Sequencer: clearing sweep, request intake, table read, update and result.
// ----------------------------------------------------------------------------
module dft_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  dft_pkg::t_sts i_sts,
    output dft_pkg::t_cmd o_cmd
);
    import dft_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/destination_failure_tracker_top.sv @@
// ----------------------------------------------------------------------------
// destination_failure_tracker_top
// Table of per-destination circuit breakers with soft/hard knockout totals.
// ----------------------------------------------------------------------------
// After reset the block sweeps the entry table to zero, one entry per cycle,
// across all NUM_DESTINATIONS entries; tready stays low until the sweep is
// done (threshold writes are taken at any time). A request then passes
// through the accept cycle, the table read, the update with write-back and
// result register load, and the output state, which shows the result until
// it is taken and holds it while m_axis tready is low. One request is in
// flight at a time, since an entry is read and written back with no
// forwarding between requests, so no new request is taken until the result
// has been taken.
module destination_failure_tracker_top #(
    parameter int NUM_DESTINATIONS = dft_pkg::NUM_DESTINATIONS_DEF,
    parameter int REQUESTER_BITS   = dft_pkg::REQUESTER_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [dft_pkg::THR_W-1:0]        i_cfg_wr_data,   // failure_threshold
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [dft_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // dest_index, requester_id
    input  logic [dft_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,  // opcode
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // responsible, in_knockout, hard_knockout, soft_knockout,
    // consecutive_failures, soft_total, hard_total
    output logic [dft_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import dft_pkg::*;

    t_cmd cmd;
    t_sts sts;

    dft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dft_datapath #(
        .NUM_DESTINATIONS (NUM_DESTINATIONS),
        .REQUESTER_BITS   (REQUESTER_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_opcode       (i_s_axis_tuser),
        .i_dest_index   (i_s_axis_tdata[DEST_W-1:0]),
        .i_requester_id (i_s_axis_tdata[DEST_W +: REQ_IN_W]),
        .o_result       (o_m_axis_tdata)
    );

`ifndef ASSERT_OFF
    // one request in flight: never taking a request while a result is shown
    a_single_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("request accepted while result pending");

    // result is valid once an accepted request has passed the READ and EXEC states
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> ##2 o_m_axis_tvalid)
        else $error("result not valid three cycles after acceptance");

    // knockout flags are consistent in every result
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (!(o_m_axis_tdata[2] && o_m_axis_tdata[3]) &&
             (o_m_axis_tdata[1] == (o_m_axis_tdata[2] || o_m_axis_tdata[3]))))
        else $error("inconsistent knockout flags");
`endif

endmodule
